// ===== sv/m3avg_pkg.sv =====
`timescale 1ns / 1ps

package m3avg_pkg;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;    // take the sample word on the input
        logic div_load;  // load the divider from the accumulator, clear the sum
        logic div_step;  // one restoring divide step
        logic out_load;  // move the quotient into the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic block_done;  // the sample on the input closes the last group of a block
        logic div_last;    // the divider is on its final step
        logic out_full;    // the output register holds an untaken word
    } sts_t;

endpackage

// ===== sv/m3avg_ctrl.sv =====
`timescale 1ns / 1ps

module m3avg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    input  m3avg_pkg::sts_t   sts,
    output m3avg_pkg::cmd_t   cmd
);

    m3avg_pkg::state_t state_reg;
    m3avg_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= m3avg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            m3avg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.block_done) begin
                        state_next = m3avg_pkg::ST_LOAD;
                    end
                end
            end
            m3avg_pkg::ST_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = m3avg_pkg::ST_DIV;
            end
            m3avg_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = m3avg_pkg::ST_DONE;
                end
            end
            m3avg_pkg::ST_DONE: begin
                // wait for room in the output register
                if (!sts.out_full || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = m3avg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = m3avg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/m3avg_dp.sv =====
`timescale 1ns / 1ps

module m3avg_dp #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [COUNT_BITS-1:0]  cfg_wdata,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   m_tready,
    input  m3avg_pkg::cmd_t        cmd,
    output m3avg_pkg::sts_t        sts,
    output logic                   m_tvalid,
    output logic [SAMPLE_BITS-1:0] average
);

    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int STEP_W = $clog2(SAMPLE_BITS);

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    logic [COUNT_BITS-1:0]  gc_reg;
    logic [SAMPLE_BITS-1:0] first_reg;
    logic [SAMPLE_BITS-1:0] second_reg;
    logic [1:0]             pos_reg;
    logic [COUNT_BITS-1:0]  groups_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [COUNT_BITS-1:0]  rem_reg;
    logic [SAMPLE_BITS-1:0] quo_reg;
    logic [STEP_W-1:0]      cnt_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic                   valid_reg;

    logic [COUNT_BITS-1:0]  n_eff;
    logic [SAMPLE_BITS-1:0] lo_xy;
    logic [SAMPLE_BITS-1:0] hi_xy;
    logic [SAMPLE_BITS-1:0] lo_hz;
    logic [SAMPLE_BITS-1:0] median;
    logic [COUNT_BITS:0]    groups_inc;
    logic [COUNT_BITS:0]    shifted;
    logic [COUNT_BITS:0]    diff;
    logic                   q_bit;

    assign n_eff = (gc_reg == '0) ? COUNT_BITS'(1) : gc_reg;

    // median = max(min(a,b), min(max(a,b),c))
    assign lo_xy  = (first_reg <= second_reg) ? first_reg : second_reg;
    assign hi_xy  = (first_reg >= second_reg) ? first_reg : second_reg;
    assign lo_hz  = (hi_xy <= sample) ? hi_xy : sample;
    assign median = (lo_xy >= lo_hz) ? lo_xy : lo_hz;

    assign groups_inc     = {1'b0, groups_reg} + (COUNT_BITS + 1)'(1);
    assign sts.block_done = (pos_reg == POS_THIRD) && (groups_inc >= {1'b0, n_eff});

    // restoring divide step; remainder stays below n
    assign shifted = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign diff    = shifted - {1'b0, n_eff};
    assign q_bit   = (shifted >= {1'b0, n_eff});

    assign sts.div_last = (cnt_reg == STEP_W'(SAMPLE_BITS - 1));
    assign sts.out_full = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gc_reg     <= COUNT_BITS'(1);
            pos_reg    <= POS_FIRST;
            groups_reg <= '0;
            sum_reg    <= '0;
            valid_reg  <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_we) begin
                // restart the group and the block
                gc_reg     <= cfg_wdata;
                pos_reg    <= POS_FIRST;
                groups_reg <= '0;
                sum_reg    <= '0;
            end else if (cmd.accept) begin
                case (pos_reg)
                    POS_FIRST:  pos_reg <= POS_SECOND;
                    POS_SECOND: pos_reg <= POS_THIRD;
                    default: begin
                        pos_reg    <= POS_FIRST;
                        sum_reg    <= sum_reg + SUM_W'(median);
                        groups_reg <= sts.block_done ? '0 : groups_inc[COUNT_BITS-1:0];
                    end
                endcase
            end else if (cmd.div_load) begin
                sum_reg <= '0;
            end

            if (cmd.div_load) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + STEP_W'(1);
            end

            if (cmd.out_load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && pos_reg == POS_FIRST) begin
            first_reg <= sample;
        end
        if (cmd.accept && pos_reg == POS_SECOND) begin
            second_reg <= sample;
        end
        if (cmd.div_load) begin
            // upper part of the sum is already below n
            rem_reg <= sum_reg[SUM_W-1:SAMPLE_BITS];
            quo_reg <= sum_reg[SAMPLE_BITS-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            quo_reg <= {quo_reg[SAMPLE_BITS-2:0], q_bit};
        end
        if (cmd.out_load) begin
            avg_reg <= quo_reg;
        end
    end

    assign m_tvalid = valid_reg;
    assign average  = avg_reg;

endmodule

// ===== sv/median_of_three_averager_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: sample
// m_        out  m_tvalid/m_tready  m_tdata: average
// cfg_      in   cfg_we             cfg_wdata: group_count (zero acts as one)
//
// A sample word that does not close a block is taken at once; the input stays ready.
// The sample that closes a block holds off the next word until the result is handed off:
// a load step, then the radix-2 restoring divider with one quotient bit per cycle,
// then the handoff to the output register.
// Reset (aresetn low, synchronous) sets group_count to 1 and clears the group.
// A full output register stalls only the handoff, while m_tready stays low.
module median_of_three_averager_core #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 10,
    localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata    // [SAMPLE_BITS-1:0] average, rest zero
);

    m3avg_pkg::cmd_t        cmd;
    m3avg_pkg::sts_t        sts;
    logic [SAMPLE_BITS-1:0] average;

    // Sequence the accept, divide and handoff steps
    m3avg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the group, accumulate medians, divide, and register the result
    m3avg_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .average   (average)
    );

    // Zero-fill the word up to whole bytes
    assign m_tdata = TDATA_W'(average);

    // Block the input for the divide after a block closes
    property p_stall_after_block;
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && sts.block_done) |=> !s_tready;
    endproperty
    a_stall_after_block: assert property (p_stall_after_block)
        else $error("input taken right after a block closed");

    // Never overwrite an untaken result
    property p_no_overwrite;
        @(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("output register overwritten while full");

    // Divide steps and sample accepts never overlap
    property p_div_excl;
        @(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.div_load, cmd.div_step, cmd.out_load});
    endproperty
    a_div_excl: assert property (p_div_excl)
        else $error("conflicting datapath commands");

endmodule
